FILE: rtl/motor_speed_pid_with_velocity_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor speed PID block
// Clocked implication checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_PID_WITH_VELOCITY_FILTER_ASSERT_SVH
`define MOTOR_SPEED_PID_WITH_VELOCITY_FILTER_ASSERT_SVH

// Same-cycle implication.
`define MSP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Widths, register indexes and fixed constants of the motor speed PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

    // Port widths
    localparam int ANGLE_W    = 12;
    localparam int VOLT_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register and state widths
    localparam int SPEED_W = 24;
    localparam int GAIN_W  = 32;
    localparam int LIMIT_W = 15;
    localparam int POLE_W  = 5;
    localparam int INT_W   = 32;

    // Datapath widths
    localparam int EDIFF_W = SPEED_W + 1;
    localparam int PROD_W  = GAIN_W + EDIFF_W;
    localparam int TOT_W   = PROD_W + 1;
    localparam int FRAC_W  = 16;
    localparam int FILT_W  = 42;

    // Low-pass coefficients, Q16: 0.9 on the old speed, 0.1 on the new
    localparam logic signed [16:0] LPF_OLD   = 17'sd58982;
    localparam logic signed [16:0] LPF_NEW   = 17'sd6554;
    localparam logic signed [16:0] LPF_ROUND = 17'sd32768;

    // Register reset values
    localparam logic signed [SPEED_W-1:0] SETPOINT_RST = 24'sd5007;
    localparam logic signed [GAIN_W-1:0]  KP_RST       = 32'sd80414;
    localparam logic signed [GAIN_W-1:0]  KI_RST       = 32'sd804;
    localparam logic signed [GAIN_W-1:0]  KD_RST       = 32'sd0;
    localparam logic [LIMIT_W-1:0]        LIMIT_RST    = 15'd4096;
    localparam logic [POLE_W-1:0]         POLE_RST     = 5'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT = 3'd0,
        CFG_KP       = 3'd1,
        CFG_KI       = 3'd2,
        CFG_KD       = 3'd3,
        CFG_LIMIT    = 3'd4,
        CFG_POLES    = 3'd5
    } t_cfg_idx;

endpackage

`default_nettype wire

FILE: rtl/motor_speed_pid_with_velocity_filter.sv
// A result is offered once its sample has passed the register chain; one sample per cycle
// unless i_ready stalls the output. The rate is set by the five-deep register chain (input,
// error/filter, products, integral, clamp), each stage holding one item; the speed filter
// and integral loops close within a single stage each. Reset (synchronous, active low)
// empties the chain, zeroes speed, integral and history state and loads the register defaults.
// ----------------------------------------------------------------------------
// Motor speed PID loop with first-order velocity filter
// One shaft angle per control tick in; drive voltage and electrical angle out.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_pid_with_velocity_filter
    import msp_pkg::*;
#(
    parameter int ANGLE_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ANGLE_W-1:0]          i_shaft_angle,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [VOLT_W-1:0]    o_drive_voltage,
    output logic [ANGLE_W-1:0]          o_electrical_angle,
    // register write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int EXT_W  = ANGLE_BITS + ANGLE_W;
    localparam int EPROD_W = ANGLE_BITS + POLE_W;
    localparam int MEAS_W = ANGLE_BITS + 8;
    localparam int SHF_W  = FILT_W - FRAC_W;
    localparam int VSH_W  = TOT_W - FRAC_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [SPEED_W-1:0] r_speed_setpoint;
    logic signed [GAIN_W-1:0]  r_kp;
    logic signed [GAIN_W-1:0]  r_ki;
    logic signed [GAIN_W-1:0]  r_kd;
    logic [LIMIT_W-1:0]        r_drive_limit;
    logic [POLE_W-1:0]         r_pole_pairs;

    // The write channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_setpoint <= SETPOINT_RST;
            r_kp             <= KP_RST;
            r_ki             <= KI_RST;
            r_kd             <= KD_RST;
            r_drive_limit    <= LIMIT_RST;
            r_pole_pairs     <= POLE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SETPOINT: r_speed_setpoint <= i_cfg_data[SPEED_W-1:0];
                CFG_KP:       r_kp             <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:       r_ki             <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:       r_kd             <= i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT:    r_drive_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_POLES:    r_pole_pairs     <= i_cfg_data[POLE_W-1:0];
                default:      ; // drop writes to indexes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage occupancy and flow control
    // A stage may load when it is empty or when its item moves on; the
    // chain of "can load" terms gives each stage a skid-free advance.
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_out_v;
    logic can_s1, can_s2, can_s3, can_s4, can_out;
    logic move_1, move_3, move_4;

    assign can_out = !r_out_v || i_ready;
    assign can_s4  = !r_s4_v  || can_out;
    assign can_s3  = !r_s3_v  || can_s4;
    assign can_s2  = !r_s2_v  || can_s3;
    assign can_s1  = !r_s1_v  || can_s2;

    assign move_1 = r_s1_v && can_s2;
    assign move_3 = r_s3_v && can_s4;
    assign move_4 = r_s4_v && can_out;

    assign o_ready = can_s1;
    assign o_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (can_s1)  r_s1_v  <= i_valid;
            if (can_s2)  r_s2_v  <= r_s1_v;
            if (can_s3)  r_s3_v  <= r_s2_v;
            if (can_s4)  r_s4_v  <= r_s3_v;
            if (can_out) r_out_v <= r_s4_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] r_s1_angle;

    always_ff @(posedge i_clk) begin
        if (can_s1 && i_valid) begin
            r_s1_angle <= i_shaft_angle;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: speed error from the previous filtered speed, new
    // speed measurement and low-pass filter, electrical angle.
    // ------------------------------------------------------------------
    logic [EXT_W-1:0]          angle_ext;
    logic [ANGLE_BITS-1:0]     angle_ab;
    logic [EPROD_W-1:0]        elec_prod;
    logic [EXT_W-1:0]          elec_ext;
    logic [ANGLE_W-1:0]        n_elec;

    logic signed [SPEED_W-1:0] r_filt;
    logic [ANGLE_BITS-1:0]     r_last_angle;
    logic signed [SPEED_W-1:0] r_last_error;

    logic signed [EDIFF_W-1:0] err_raw;
    logic signed [SPEED_W-1:0] n_error;
    logic signed [EDIFF_W-1:0] n_ediff;

    logic [ANGLE_BITS-1:0]     diff_u;
    logic signed [MEAS_W-1:0]  measured;
    logic signed [FILT_W-1:0]  filt_old_p;
    logic signed [FILT_W-1:0]  filt_new_p;
    logic signed [FILT_W-1:0]  filt_sum;
    logic signed [SHF_W-1:0]   filt_shf;
    logic signed [SPEED_W-1:0] n_filt;

    // Bits of the sample at and above ANGLE_BITS play no part.
    assign angle_ext = EXT_W'(r_s1_angle);
    assign angle_ab  = angle_ext[ANGLE_BITS-1:0];

    // Electrical angle wraps at one turn.
    assign elec_prod = EPROD_W'(angle_ab) * EPROD_W'(r_pole_pairs);
    assign elec_ext  = EXT_W'(elec_prod[ANGLE_BITS-1:0]);
    assign n_elec    = elec_ext[ANGLE_W-1:0];

    // Error, saturated to the speed width.
    assign err_raw = EDIFF_W'(r_speed_setpoint) - EDIFF_W'(r_filt);

    always_comb begin
        if (err_raw[EDIFF_W-1] != err_raw[EDIFF_W-2]) begin
            n_error = err_raw[EDIFF_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}}
                                         : {1'b0, {(SPEED_W-1){1'b1}}};
        end else begin
            n_error = err_raw[SPEED_W-1:0];
        end
    end

    assign n_ediff = EDIFF_W'(n_error) - EDIFF_W'(r_last_error);

    // Wrapped angle step, read as signed; a zero crossing is a small step.
    assign diff_u   = angle_ab - r_last_angle;
    assign measured = {$signed(diff_u), 8'b0};

    assign filt_old_p = FILT_W'(LPF_OLD) * FILT_W'(r_filt);
    assign filt_new_p = FILT_W'(LPF_NEW) * FILT_W'(measured);
    assign filt_sum   = filt_old_p + filt_new_p + FILT_W'(LPF_ROUND);
    // Upper bits of the sum are the floor of the division by 2^16.
    assign filt_shf   = filt_sum[FILT_W-1:FRAC_W];

    always_comb begin
        if (!(&filt_shf[SHF_W-1:SPEED_W-1]) && (|filt_shf[SHF_W-1:SPEED_W-1])) begin
            n_filt = filt_shf[SHF_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}}
                                       : {1'b0, {(SPEED_W-1){1'b1}}};
        end else begin
            n_filt = filt_shf[SPEED_W-1:0];
        end
    end

    // Advance the loop state once per item, as it leaves stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt       <= '0;
            r_last_angle <= '0;
            r_last_error <= '0;
        end else if (move_1) begin
            r_filt       <= n_filt;
            r_last_angle <= angle_ab;
            r_last_error <= n_error;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: error terms; gain products
    // ------------------------------------------------------------------
    logic signed [SPEED_W-1:0] r_s2_error;
    logic signed [EDIFF_W-1:0] r_s2_ediff;
    logic [ANGLE_W-1:0]        r_s2_elec;

    always_ff @(posedge i_clk) begin
        if (move_1) begin
            r_s2_error <= n_error;
            r_s2_ediff <= n_ediff;
            r_s2_elec  <= n_elec;
        end
    end

    logic signed [PROD_W-1:0] n_p_term;
    logic signed [PROD_W-1:0] n_i_term;
    logic signed [PROD_W-1:0] n_d_term;

    assign n_p_term = PROD_W'(r_kp) * PROD_W'(r_s2_error);
    assign n_i_term = PROD_W'(r_ki) * PROD_W'(r_s2_error);
    assign n_d_term = PROD_W'(r_kd) * PROD_W'(r_s2_ediff);

    // ------------------------------------------------------------------
    // Stage 3: registered products; integral update, P plus D
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_s3_p;
    logic signed [PROD_W-1:0] r_s3_i;
    logic signed [PROD_W-1:0] r_s3_d;
    logic [ANGLE_W-1:0]       r_s3_elec;

    always_ff @(posedge i_clk) begin
        if (r_s2_v && can_s3) begin
            r_s3_p    <= n_p_term;
            r_s3_i    <= n_i_term;
            r_s3_d    <= n_d_term;
            r_s3_elec <= r_s2_elec;
        end
    end

    logic signed [INT_W-1:0] r_int;
    logic signed [TOT_W-1:0] int_sum;
    logic signed [INT_W-1:0] n_int;
    logic signed [TOT_W-1:0] n_pd;

    assign int_sum = TOT_W'(r_int) + TOT_W'(r_s3_i);

    // Integral saturates at its own 32-bit range.
    always_comb begin
        if (!(&int_sum[TOT_W-1:INT_W-1]) && (|int_sum[TOT_W-1:INT_W-1])) begin
            n_int = int_sum[TOT_W-1] ? {1'b1, {(INT_W-1){1'b0}}}
                                     : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
            n_int = int_sum[INT_W-1:0];
        end
    end

    assign n_pd = TOT_W'(r_s3_p) + TOT_W'(r_s3_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int <= '0;
        end else if (move_3) begin
            r_int <= n_int;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: total, scale to volts, clamp to the drive limit
    // ------------------------------------------------------------------
    logic signed [TOT_W-1:0] r_s4_pd;
    logic signed [INT_W-1:0] r_s4_int;
    logic [ANGLE_W-1:0]      r_s4_elec;

    always_ff @(posedge i_clk) begin
        if (move_3) begin
            r_s4_pd   <= n_pd;
            r_s4_int  <= n_int;
            r_s4_elec <= r_s3_elec;
        end
    end

    logic signed [TOT_W-1:0]  total;
    logic signed [VSH_W-1:0]  volt_full;
    logic signed [VSH_W-1:0]  lim_pos;
    logic signed [VSH_W-1:0]  lim_neg;
    logic signed [VOLT_W-1:0] n_volt;

    assign total     = r_s4_pd + TOT_W'(r_s4_int);
    assign volt_full = total[TOT_W-1:FRAC_W];
    assign lim_pos   = VSH_W'({1'b0, r_drive_limit});
    assign lim_neg   = -lim_pos;

    always_comb begin
        if (volt_full > lim_pos) begin
            n_volt = lim_pos[VOLT_W-1:0];
        end else if (volt_full < lim_neg) begin
            n_volt = lim_neg[VOLT_W-1:0];
        end else begin
            n_volt = volt_full[VOLT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a result until its transfer, while the
    // stages behind it keep taking samples until each of them is full.
    // ------------------------------------------------------------------
    logic signed [VOLT_W-1:0] r_out_volt;
    logic [ANGLE_W-1:0]       r_out_elec;

    always_ff @(posedge i_clk) begin
        if (move_4) begin
            r_out_volt <= n_volt;
            r_out_elec <= r_s4_elec;
        end
    end

    assign o_drive_voltage    = r_out_volt;
    assign o_electrical_angle = r_out_elec;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic signed [VOLT_W-1:0] chk_limit;

    assign chk_limit = {1'b0, r_drive_limit};

`include "motor_speed_pid_with_velocity_filter_assert.svh"

    // A shown result never leaves the symmetric clamp.
    `MSP_ASSERT_IMP(a_volt_in_limit, i_clk, i_rst_n, o_valid, (o_drive_voltage <= chk_limit) && (o_drive_voltage >= -chk_limit), "drive voltage outside limit")

    // Zero pole pairs give a zero electrical angle.
    `MSP_ASSERT_IMP(a_elec_zero_poles, i_clk, i_rst_n, o_valid && (r_pole_pairs == '0), o_electrical_angle == '0, "electrical angle with zero pole pairs")

    // The filtered speed moves only when an item leaves stage 1.
    `MSP_ASSERT_NXT(a_filt_hold, i_clk, i_rst_n, !move_1, $stable(r_filt), "speed filter moved without an item")

endmodule

`default_nettype wire
